@@ rtl/set_associative_lru_cache_check_macros.svh @@
// ----------------------------------------------------------------------------
// set_associative_lru_cache_check_macros.svh
// Assertion macros shared by the cache checker.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOCIATIVE_LRU_CACHE_CHECK_MACROS_SVH
`define SET_ASSOCIATIVE_LRU_CACHE_CHECK_MACROS_SVH

// Same-cycle implication, masked while reset is held
`define SLRU_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is held
`define SLRU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also runs through reset
`define SLRU_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/slru_pkg.sv @@
// ----------------------------------------------------------------------------
// slru_pkg
// Shared constants and controller/datapath interface types for the
// set-associative LRU tag cache.
// ----------------------------------------------------------------------------
package slru_pkg;

    // Geometry defaults
    localparam int SETS_DEF = 64;
    localparam int WAYS_DEF = 4;

    // Field widths
    localparam int ADDR_W    = 32;
    localparam int TAG_W     = 32;
    localparam int TS_W      = 32;
    localparam int OFF_W     = 5;
    localparam int SET_OUT_W = 6;
    localparam int WAY_OUT_W = 2;

    // Block offset after reset
    localparam logic [OFF_W-1:0] OFF_RESET = 5'd2;

    // Remainder unit: tag bits folded per cycle, and steps per tag
    localparam int MOD_STEP_BITS = 4;
    localparam int MOD_STEPS     = TAG_W / MOD_STEP_BITS;

    // Commands from controller to datapath
    typedef struct packed {
        logic clr_en;     // write one cleared row
        logic accept;     // latch a new address
        logic mod_step;   // advance the remainder unit
        logic rd_en;      // read the selected set
        logic scan_init;  // start the oldest-way search
        logic scan_step;  // examine the next way
        logic commit;     // write the row back, bump counter, load result
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic clr_last;
        logic mod_done;
        logic hit;
        logic scan_last;
    } t_sts;

endpackage

@@ rtl/slru_ctrl.sv @@
// ----------------------------------------------------------------------------
// slru_ctrl
// Sequencer for the tag cache: clearing pass, set selection, set read,
// lookup, oldest-way search and write-back. Owns the result valid flag.
// ----------------------------------------------------------------------------
module slru_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_out_stall,
    input  slru_pkg::t_sts i_sts,
    output slru_pkg::t_cmd o_cmd,
    output logic           o_in_stall,
    output logic           o_out_valid
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_MOD   = 5'b00100,
        S_LOOK  = 5'b01000,
        S_SCAN  = 5'b10000
    } t_state;

    t_state         r_state;
    t_state         n_state;
    logic           r_out_valid;
    logic           n_out_valid;
    logic           out_free;
    slru_pkg::t_cmd cmd;

    // The result register can take a value when empty or being drained
    assign out_free = !r_out_valid || !i_out_stall;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_CLEAR: begin
                cmd.clr_en = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    n_state    = S_MOD;
                end
            end
            S_MOD: begin
                if (i_sts.mod_done) begin
                    cmd.rd_en = 1'b1;
                    n_state   = S_LOOK;
                end else begin
                    cmd.mod_step = 1'b1;
                end
            end
            S_LOOK: begin
                if (i_sts.hit) begin
                    if (out_free) begin
                        cmd.commit = 1'b1;
                        n_state    = S_IDLE;
                    end
                end else begin
                    cmd.scan_init = 1'b1;
                    n_state       = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_last) begin
                    if (out_free) begin
                        cmd.commit = 1'b1;
                        n_state    = S_IDLE;
                    end
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Result valid: set on write-back, drop once taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/slru_dp.sv @@
// ----------------------------------------------------------------------------
// slru_dp
// Datapath of the tag cache: offset register, tag shift, set remainder,
// set memories (valid, tag, timestamp), lookup, oldest-way search,
// access counter and the result register.
// ----------------------------------------------------------------------------
module slru_dp #(
    parameter int SETS = slru_pkg::SETS_DEF,
    parameter int WAYS = slru_pkg::WAYS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  slru_pkg::t_cmd                  i_cmd,
    output slru_pkg::t_sts                  o_sts,
    input  logic                            i_cfg_wr_en,
    input  logic [slru_pkg::OFF_W-1:0]      i_cfg_wr_data,
    input  logic [slru_pkg::ADDR_W-1:0]     i_address,
    output logic                            o_hit,
    output logic [slru_pkg::SET_OUT_W-1:0]  o_set_index,
    output logic [slru_pkg::TAG_W-1:0]      o_block_tag,
    output logic [slru_pkg::WAY_OUT_W-1:0]  o_way_used
);

    localparam int TAG_W     = slru_pkg::TAG_W;
    localparam int TS_W      = slru_pkg::TS_W;
    localparam int SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int IDX_W     = $clog2(WAYS + 1);
    localparam int SET_OUT_W = slru_pkg::SET_OUT_W;
    localparam int WAY_OUT_W = slru_pkg::WAY_OUT_W;
    localparam bit SETS_POW2 = ((SETS & (SETS - 1)) == 0);

    // Block offset register
    logic [slru_pkg::OFF_W-1:0] r_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= slru_pkg::OFF_RESET;
        end else if (i_cfg_wr_en) begin
            r_offset <= i_cfg_wr_data;
        end
    end

    // Block tag of the accepted address
    logic [TAG_W-1:0] tag_in;
    logic [TAG_W-1:0] r_tag;

    assign tag_in = i_address >> r_offset;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_tag <= tag_in;
        end
    end

    // Set selection: tag modulo SETS
    logic [SET_W-1:0] set_q;
    logic             mod_done;

    generate
        if (SETS == 1) begin : g_set_single
            assign set_q    = '0;
            assign mod_done = 1'b1;
        end else if (SETS_POW2) begin : g_set_mask
            assign set_q    = r_tag[SET_W-1:0];
            assign mod_done = 1'b1;
        end else begin : g_set_rem
            localparam int REM_W  = SET_W + 1;
            localparam int MCNT_W = $clog2(slru_pkg::MOD_STEPS + 1);
            localparam int STEP_B = slru_pkg::MOD_STEP_BITS;

            logic [TAG_W-1:0]  r_mtag;
            logic [REM_W-1:0]  r_rem;
            logic [REM_W-1:0]  n_rem;
            logic [MCNT_W-1:0] r_mcnt;

            // Fold STEP_B tag bits into the remainder, one compare-subtract each
            always_comb begin
                n_rem = r_rem;
                for (int k = 0; k < STEP_B; k++) begin
                    n_rem = {n_rem[REM_W-2:0], r_mtag[TAG_W-1-k]};
                    if (n_rem >= REM_W'(SETS)) begin
                        n_rem = n_rem - REM_W'(SETS);
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_mcnt <= '0;
                end else if (i_cmd.accept) begin
                    r_mcnt <= '0;
                end else if (i_cmd.mod_step) begin
                    r_mcnt <= r_mcnt + MCNT_W'(1);
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_cmd.accept) begin
                    r_mtag <= tag_in;
                    r_rem  <= '0;
                end else if (i_cmd.mod_step) begin
                    r_mtag <= r_mtag << STEP_B;
                    r_rem  <= n_rem;
                end
            end

            assign set_q    = r_rem[SET_W-1:0];
            assign mod_done = (r_mcnt == MCNT_W'(slru_pkg::MOD_STEPS));
        end
    endgenerate

    // Set memories, one row per set
    logic [WAYS-1:0]             mem_v   [SETS];
    logic [WAYS-1:0][TAG_W-1:0]  mem_tag [SETS];
    logic [WAYS-1:0][TS_W-1:0]   mem_ts  [SETS];

    logic [WAYS-1:0]             r_rd_v;
    logic [WAYS-1:0][TAG_W-1:0]  r_rd_tag;
    logic [WAYS-1:0][TS_W-1:0]   r_rd_ts;

    logic [WAYS-1:0]             row_v;
    logic [WAYS-1:0][TAG_W-1:0]  row_tag;
    logic [WAYS-1:0][TS_W-1:0]   row_ts;

    logic                        wr_en;
    logic [SET_W-1:0]            wr_addr;
    logic [SET_W-1:0]            r_clr_addr;

    // Clearing pass address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_en) begin
            r_clr_addr <= r_clr_addr + SET_W'(1);
        end
    end

    assign wr_en   = i_cmd.clr_en || i_cmd.commit;
    assign wr_addr = i_cmd.clr_en ? r_clr_addr : set_q;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_v[wr_addr]   <= i_cmd.clr_en ? '0 : row_v;
            mem_tag[wr_addr] <= i_cmd.clr_en ? '0 : row_tag;
            mem_ts[wr_addr]  <= i_cmd.clr_en ? '0 : row_ts;
        end
        if (i_cmd.rd_en) begin
            r_rd_v   <= mem_v[set_q];
            r_rd_tag <= mem_tag[set_q];
            r_rd_ts  <= mem_ts[set_q];
        end
    end

    // Lookup: lowest valid way holding the tag
    logic             hit;
    logic [WAY_W-1:0] hit_way;

    always_comb begin
        hit     = 1'b0;
        hit_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (r_rd_v[w] && (r_rd_tag[w] == r_tag)) begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
        end
    end

    // Oldest-way search, one way per cycle, lowest index kept on ties
    logic [IDX_W-1:0] r_scan_idx;
    logic [WAY_W-1:0] r_best;
    logic [TS_W-1:0]  r_best_ts;
    logic [TS_W-1:0]  scan_ts;

    assign scan_ts = r_rd_ts[r_scan_idx[WAY_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_scan_idx <= IDX_W'(1);
            r_best     <= '0;
            r_best_ts  <= r_rd_ts[0];
        end else if (i_cmd.scan_step) begin
            r_scan_idx <= r_scan_idx + IDX_W'(1);
            if (scan_ts < r_best_ts) begin
                r_best    <= r_scan_idx[WAY_W-1:0];
                r_best_ts <= scan_ts;
            end
        end
    end

    // Access counter, advanced once per transaction
    logic [TS_W-1:0] r_counter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= '0;
        end else if (i_cmd.commit) begin
            r_counter <= r_counter + TS_W'(1);
        end
    end

    // Updated row: chosen way becomes valid with the tag and current time
    logic [WAY_W-1:0] way_sel;

    assign way_sel = hit ? hit_way : r_best;

    always_comb begin
        row_v            = r_rd_v;
        row_tag          = r_rd_tag;
        row_ts           = r_rd_ts;
        row_v[way_sel]   = 1'b1;
        row_tag[way_sel] = r_tag;
        row_ts[way_sel]  = r_counter;
    end

    // Result register
    logic [SET_W+SET_OUT_W-1:0] set_ext;
    logic [WAY_W+WAY_OUT_W-1:0] way_ext;
    logic                       r_o_hit;
    logic [SET_OUT_W-1:0]       r_o_set;
    logic [TAG_W-1:0]           r_o_tag;
    logic [WAY_OUT_W-1:0]       r_o_way;

    assign set_ext = {{SET_OUT_W{1'b0}}, set_q};
    assign way_ext = {{WAY_OUT_W{1'b0}}, way_sel};

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_o_hit <= hit;
            r_o_set <= set_ext[SET_OUT_W-1:0];
            r_o_tag <= r_tag;
            r_o_way <= way_ext[WAY_OUT_W-1:0];
        end
    end

    assign o_hit       = r_o_hit;
    assign o_set_index = r_o_set;
    assign o_block_tag = r_o_tag;
    assign o_way_used  = r_o_way;

    // Status to the controller
    assign o_sts.clr_last  = (r_clr_addr == SET_W'(SETS - 1));
    assign o_sts.mod_done  = mod_done;
    assign o_sts.hit       = hit;
    assign o_sts.scan_last = (r_scan_idx == IDX_W'(WAYS));

endmodule

@@ rtl/set_associative_lru_cache_check.sv @@
// ----------------------------------------------------------------------------
// set_associative_lru_cache_check
// Tag-only set-associative cache with least-recently-used replacement.
// Reports hit or miss, set, block tag and the way used for each address.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+------------------------------
//  address   | in        | i_valid / o_stall    | i_address
//  result    | out       | o_valid / i_stall    | o_hit o_set_index o_block_tag
//            |           |                      | o_way_used
//  config    | in        | i_cfg_wr_en          | i_cfg_wr_data
//
//  One transaction at a time: the set is selected, read and looked up; a
//  hit goes straight to write-back, a miss first searches for the oldest
//  way, one way per cycle. The next address is taken only after write-back.
//  A SETS that is not a power of two adds a stepwise set remainder. After
//  reset a clearing pass over all SETS rows holds o_stall high. A stalled
//  result holds in the output register; write-back waits until it is free.
// ----------------------------------------------------------------------------
module set_associative_lru_cache_check #(
    parameter int SETS = slru_pkg::SETS_DEF,
    parameter int WAYS = slru_pkg::WAYS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration
    input  logic                            i_cfg_wr_en,
    input  logic [slru_pkg::OFF_W-1:0]      i_cfg_wr_data,
    // Address channel
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [slru_pkg::ADDR_W-1:0]     i_address,
    // Result channel
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_hit,
    output logic [slru_pkg::SET_OUT_W-1:0]  o_set_index,
    output logic [slru_pkg::TAG_W-1:0]      o_block_tag,
    output logic [slru_pkg::WAY_OUT_W-1:0]  o_way_used
);

    slru_pkg::t_cmd cmd;
    slru_pkg::t_sts sts;

    // Sequencer
    slru_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_out_stall (i_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid)
    );

    // Datapath
    slru_dp #(
        .SETS (SETS),
        .WAYS (WAYS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_address     (i_address),
        .o_hit         (o_hit),
        .o_set_index   (o_set_index),
        .o_block_tag   (o_block_tag),
        .o_way_used    (o_way_used)
    );

endmodule

@@ rtl/slru_checker.sv @@
// ----------------------------------------------------------------------------
// slru_checker
// Port-level checks on the tag cache, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "set_associative_lru_cache_check_macros.svh"

module slru_checker #(
    parameter int SETS = slru_pkg::SETS_DEF,
    parameter int WAYS = slru_pkg::WAYS_DEF
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_stall,
    input logic                            o_valid,
    input logic                            i_stall,
    input logic                            o_hit,
    input logic [slru_pkg::SET_OUT_W-1:0]  o_set_index,
    input logic [slru_pkg::TAG_W-1:0]      o_block_tag,
    input logic [slru_pkg::WAY_OUT_W-1:0]  o_way_used
);

    logic [slru_pkg::TAG_W-1:0] exp_set;
    logic                       way_ok;

    assign exp_set = o_block_tag % slru_pkg::TAG_W'(SETS);
    assign way_ok  = (WAYS > 4) || (32'(o_way_used) < 32'(WAYS));

    // Hold a stalled result
    `SLRU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_hit) && $stable(o_set_index) && $stable(o_block_tag)
        && $stable(o_way_used), "stalled result changed")

    // Go busy after taking an address
    `SLRU_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall,
        o_stall, "second address taken before the first finished")

    // New results only arrive from a busy cycle
    `SLRU_ASSERT_IMPLY(a_result_from_work, i_clk, i_rst_n, $rose(o_valid),
        $past(o_stall), "result appeared without work in progress")

    // Set and way agree with the tag and the geometry
    `SLRU_ASSERT_IMPLY(a_set_way, i_clk, i_rst_n, o_valid,
        (o_set_index == exp_set[slru_pkg::SET_OUT_W-1:0]) && way_ok,
        "set index or way out of step with tag")

    // Clear and hold off traffic after reset
    `SLRU_ASSERT_NEXT_ALWAYS(a_reset_clear, i_clk, !i_rst_n, o_stall && !o_valid,
        "block not busy and empty after reset")

endmodule

bind set_associative_lru_cache_check slru_checker #(
    .SETS (SETS),
    .WAYS (WAYS)
) u_slru_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_hit       (o_hit),
    .o_set_index (o_set_index),
    .o_block_tag (o_block_tag),
    .o_way_used  (o_way_used)
);
